FILE: hdl/scs1_pkg.sv
// Shared types, constants and the extended-code lookup for the set-1 event decoder.
package scs1_pkg;

  // Multi-byte codes with fixed event ids.
  localparam logic [47:0] CodePause      = 48'hE11D45E19DC5;
  localparam logic [31:0] CodePrtscMake  = 32'hE02AE037;
  localparam logic [31:0] CodePrtscBreak = 32'hE0B7E0AA;

  localparam logic [7:0] PrefixExt   = 8'hE0;
  localparam logic [7:0] ExtFakeMake = 8'h2A;
  localparam logic [7:0] ExtFakeBrk  = 8'hB7;

  localparam logic [7:0] IdPrtscMake  = 8'hFD;
  localparam logic [7:0] IdPrtscBreak = 8'hFE;
  localparam logic [7:0] IdPause      = 8'hFF;

  // Outcome of one decode step.
  typedef struct packed {
    logic       fire;
    logic       invalid;
    logic [7:0] key_id;
  } step_result_t;

  // Result of looking up the second byte of an E0 code.
  typedef struct packed {
    logic       hit;
    logic [7:0] id;
  } ext_hit_t;

  // Maps the byte after E0 to its event id. Bytes below 9C use the first
  // table (ids 59-80), bytes from 9C up use the second (ids D9-FC). ED has
  // no id because it lies past EC, the highest byte in the second table.
  function automatic ext_hit_t ext_lookup(input logic [7:0] code);
    ext_hit_t r;
    r.hit = 1'b1;
    r.id  = 8'h00;
    case (code)
      8'h10: r.id = 8'h59;
      8'h19: r.id = 8'h5A;
      8'h1C: r.id = 8'h5B;
      8'h1D: r.id = 8'h5C;
      8'h20: r.id = 8'h5D;
      8'h21: r.id = 8'h5E;
      8'h22: r.id = 8'h5F;
      8'h24: r.id = 8'h60;
      8'h2E: r.id = 8'h61;
      8'h30: r.id = 8'h62;
      8'h32: r.id = 8'h63;
      8'h35: r.id = 8'h64;
      8'h38: r.id = 8'h65;
      8'h47: r.id = 8'h66;
      8'h48: r.id = 8'h67;
      8'h49: r.id = 8'h68;
      8'h4B: r.id = 8'h69;
      8'h4D: r.id = 8'h6A;
      8'h4F: r.id = 8'h6B;
      8'h50: r.id = 8'h6C;
      8'h51: r.id = 8'h6D;
      8'h52: r.id = 8'h6E;
      8'h53: r.id = 8'h6F;
      8'h5B: r.id = 8'h70;
      8'h5C: r.id = 8'h71;
      8'h5D: r.id = 8'h72;
      8'h5E: r.id = 8'h73;
      8'h5F: r.id = 8'h74;
      8'h63: r.id = 8'h75;
      8'h65: r.id = 8'h76;
      8'h66: r.id = 8'h77;
      8'h67: r.id = 8'h78;
      8'h68: r.id = 8'h79;
      8'h69: r.id = 8'h7A;
      8'h6A: r.id = 8'h7B;
      8'h6B: r.id = 8'h7C;
      8'h6C: r.id = 8'h7D;
      8'h6D: r.id = 8'h7E;
      8'h90: r.id = 8'h7F;
      8'h99: r.id = 8'h80;
      8'h9C: r.id = 8'hD9;
      8'h9D: r.id = 8'hDA;
      8'hA0: r.id = 8'hDB;
      8'hA1: r.id = 8'hDC;
      8'hA2: r.id = 8'hDD;
      8'hA4: r.id = 8'hDE;
      8'hAE: r.id = 8'hDF;
      8'hB0: r.id = 8'hE0;
      8'hB2: r.id = 8'hE1;
      8'hB5: r.id = 8'hE2;
      8'hB8: r.id = 8'hE3;
      8'hC7: r.id = 8'hE4;
      8'hC8: r.id = 8'hE5;
      8'hC9: r.id = 8'hE6;
      8'hCB: r.id = 8'hE7;
      8'hCD: r.id = 8'hE8;
      8'hCF: r.id = 8'hE9;
      8'hD0: r.id = 8'hEA;
      8'hD1: r.id = 8'hEB;
      8'hD2: r.id = 8'hEC;
      8'hD3: r.id = 8'hED;
      8'hDB: r.id = 8'hEE;
      8'hDC: r.id = 8'hEF;
      8'hDD: r.id = 8'hF0;
      8'hDE: r.id = 8'hF1;
      8'hDF: r.id = 8'hF2;
      8'hE3: r.id = 8'hF3;
      8'hE5: r.id = 8'hF4;
      8'hE6: r.id = 8'hF5;
      8'hE7: r.id = 8'hF6;
      8'hE8: r.id = 8'hF7;
      8'hE9: r.id = 8'hF8;
      8'hEA: r.id = 8'hF9;
      8'hEB: r.id = 8'hFA;
      8'hEC: r.id = 8'hFB;
      8'hE0: r.id = 8'hFC;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/scs1_in_if.sv
// Channel carrying received scan-code bytes.
interface scs1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

FILE: hdl/scs1_out_if.sv
// Channel carrying decoded key event words.
interface scs1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_id;
  logic       invalid;

  modport source (output valid, output key_id, output invalid, input ready);
  modport sink (input valid, input key_id, input invalid, output ready);
endinterface

FILE: hdl/scs1_step.sv
// Combinational decode step: shifts one byte into the accumulator and classifies the code.
module scs1_step (
  input  logic [47:0]          acc,
  input  logic [7:0]           scan_byte,
  output logic [47:0]          acc_next,
  output scs1_pkg::step_result_t result
);
  import scs1_pkg::*;

  logic [47:0] shifted;
  logic [7:0]  low;
  logic        complete;
  logic        mapped;
  logic [7:0]  id;
  ext_hit_t    ext;

  assign shifted = {acc[39:0], scan_byte};
  assign low     = shifted[7:0];
  assign ext     = ext_lookup(low);

  // Classify the shifted code by its significant length.
  always_comb begin
    complete = 1'b0;
    mapped   = 1'b0;
    id       = 8'h00;
    if (shifted[47:8] == 40'd0) begin
      complete = low inside {[8'h01:8'h53], [8'h57:8'h58], [8'h81:8'hD3], [8'hD7:8'hD8]};
      mapped   = 1'b1;
      id       = low;
    end else if (shifted[47:16] == 32'd0) begin
      complete = (shifted[15:8] == PrefixExt) && (low != ExtFakeMake) && (low != ExtFakeBrk);
      mapped   = ext.hit;
      id       = ext.id;
    end else if (shifted[47:32] == 16'd0) begin
      complete = (shifted[31:0] == CodePrtscMake) || (shifted[31:0] == CodePrtscBreak);
      mapped   = 1'b1;
      id       = (shifted[31:0] == CodePrtscMake) ? IdPrtscMake : IdPrtscBreak;
    end else begin
      complete = (shifted == CodePause);
      mapped   = 1'b1;
      id       = IdPause;
    end
  end

  // An overlong sequence drops the byte and reports invalid; a complete code
  // reports its id, or invalid when it has none, and clears the accumulator.
  always_comb begin
    result.fire    = 1'b0;
    result.invalid = 1'b0;
    result.key_id  = 8'h00;
    acc_next       = shifted;
    if (acc[47:40] != 8'd0) begin
      result.fire    = 1'b1;
      result.invalid = 1'b1;
      acc_next       = 48'd0;
    end else if (complete) begin
      result.fire    = 1'b1;
      result.invalid = !mapped;
      result.key_id  = mapped ? id : 8'h00;
      acc_next       = 48'd0;
    end
  end

endmodule

FILE: hdl/scancode_set1_event_decoder_unit.sv
// Top level of the scan code set 1 event decoder.
//
// The scan_bytes channel takes one received keyboard byte per word. Bytes are
// collected in a 48-bit accumulator until they form a complete set-1 code;
// then one word leaves on the key_events channel with its event id, or with
// invalid set and a zero id when the code has no id or the sequence grew past
// six bytes. Bytes that leave the code incomplete produce no word.
//
// Each byte is registered on acceptance and decoded combinationally from the
// input register straight into the output register, unless a held result
// word stalls it. A new byte can be accepted every cycle while key_events does
// not stall; the rate is set by the single decode pass between the input and
// output registers.
//
// When key_events stalls, the output register holds its word and the input
// register still takes one more byte; scan_bytes.ready then drops until the
// held word is taken. Synchronous reset clears the accumulator and empties
// both registers.
module scancode_set1_event_decoder_unit (
  input logic       clk,
  input logic       rst,
  scs1_in_if.sink   scan_bytes,
  scs1_out_if.source key_events
);
  import scs1_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic [47:0]  acc;
  logic [47:0]  acc_next;
  logic         out_valid;
  logic [7:0]   out_id;
  logic         out_invalid;
  logic         adv;
  step_result_t step;

  // A held byte moves on when the output register is free this cycle.
  assign adv              = s1_valid && (!out_valid || key_events.ready);
  assign scan_bytes.ready = !s1_valid || adv;

  assign key_events.valid   = out_valid;
  assign key_events.key_id  = out_id;
  assign key_events.invalid = out_invalid;

  scs1_step u_step (
    .acc      (acc),
    .scan_byte(s1_byte),
    .acc_next (acc_next),
    .result   (step)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_bytes.valid && scan_bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (scan_bytes.valid && scan_bytes.ready) begin
      s1_byte <= scan_bytes.scan_byte;
    end
  end

  // Accumulator and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 48'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        acc <= acc_next;
      end
      if (adv && step.fire) begin
        out_valid <= 1'b1;
      end else if (key_events.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (adv && step.fire) begin
      out_id      <= step.key_id;
      out_invalid <= step.invalid;
    end
  end

  // An invalid word always carries a zero id.
  a_invalid_zero_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_invalid) |-> (out_id == 8'h00))
    else $error("invalid word with nonzero event id");

  // An overlong sequence clears the accumulator and raises a word.
  a_overlong_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && (acc[47:40] != 8'd0)) |=> ((acc == 48'd0) && out_valid && out_invalid))
    else $error("overlong sequence not cleared");

  // A stalled result word blocks the decode pass.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_events.ready) |-> !adv)
    else $error("decode advanced over a stalled word");

endmodule
